[design/flc_pkg.sv]
// shared types and constants for the full linear convolution block
`default_nettype none

package flc_pkg;

  localparam int SUM_BITS      = 36;
  localparam int REG_TAPS      = 16;
  localparam int TAPS_PER_REG  = 4;
  localparam int SLOT_BITS     = 16;
  localparam int CFG_DATA_BITS = 64;
  localparam int CFG_IDX_BITS  = 3;
  localparam int TAP_CNT_BITS  = 5;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_TAP_COUNT = 3'd0,
    CFG_COEFF_0   = 3'd1,
    CFG_COEFF_1   = 3'd2,
    CFG_COEFF_2   = 3'd3,
    CFG_COEFF_3   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic shift;
    logic clr;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[design/flc_cell.sv]
// one transposed-form cell: multiply-accumulate into a partial sum, shift to neighbor
`default_nettype none

module flc_cell #(
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire flc_pkg::cell_ctrl_t                ctrl,
  input  wire logic                               mac_en,
  input  wire logic signed [SAMPLE_BITS-1:0]      sample,
  input  wire logic signed [COEFF_BITS-1:0]       coeff,
  input  wire logic signed [flc_pkg::SUM_BITS-1:0] sum_in,
  output logic signed [flc_pkg::SUM_BITS-1:0]      sum_out
);

  localparam int SB = flc_pkg::SUM_BITS;
  localparam int PB = SAMPLE_BITS + COEFF_BITS;

  logic signed [PB-1:0] prod;
  logic signed [SB-1:0] psum_r;
  logic signed [SB-1:0] psum_nxt;

  assign prod    = sample * coeff;
  assign sum_out = mac_en ? (psum_r + SB'(prod)) : psum_r;

  always_comb begin
    psum_nxt = psum_r;
    if (ctrl.clr) begin
      psum_nxt = '0;
    end else if (ctrl.shift) begin
      psum_nxt = sum_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      psum_r <= '0;
    end else begin
      psum_r <= psum_nxt;
    end
  end

endmodule

`default_nettype wire

[design/full_linear_convolution.sv]
// top level: configuration registers, cell chain, tail drain and output register
//
//   port group   dir   handshake        payload
//   in_          in    valid / stall    sample, last_sample
//   out_         out   valid / stall    filtered_value, last_result
//   cfg_         in    write enable     index, data
//
// one sample per cycle while in_stall is low; every sample gives one result in the next cycle
// a last sample brings n_use-1 tail beats, one per cycle while out_free, input stalled meanwhile
// the rate is set by the one multiply-accumulate per cell in each cycle
// reset is synchronous and clears the partial sums, tap_count to 1 and tap 0 to 1
// out_stall holds the output register; the input also stalls while it is full and held

`default_nettype none

module full_linear_convolution #(
  parameter int MAX_TAPS    = 16,
  parameter int SAMPLE_BITS = 16,
  parameter int COEFF_BITS  = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [SAMPLE_BITS-1:0]         in_sample,
  input  wire logic                                  in_last_sample,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [flc_pkg::SUM_BITS-1:0]        out_filtered_value,
  output logic                                       out_last_result,
  input  wire logic                                  cfg_we,
  input  wire logic [flc_pkg::CFG_IDX_BITS-1:0]      cfg_index,
  input  wire logic [flc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

  localparam int SB   = flc_pkg::SUM_BITS;
  localparam int TCW  = flc_pkg::TAP_CNT_BITS;
  localparam int LIM  = (MAX_TAPS < flc_pkg::REG_TAPS) ? MAX_TAPS : flc_pkg::REG_TAPS;
  localparam int CUSE = (COEFF_BITS < flc_pkg::SLOT_BITS) ? COEFF_BITS : flc_pkg::SLOT_BITS;
  localparam int DCW  = 4;

  logic [TCW-1:0]                     tap_count_r;
  logic [flc_pkg::CFG_DATA_BITS-1:0]  coeff_r [flc_pkg::TAPS_PER_REG];
  logic [TCW-1:0]                     n_use;
  logic [DCW-1:0]                     drain_r;
  logic [DCW-1:0]                     drain_nxt;
  logic                               draining;
  logic                               out_free;
  logic                               in_fire;
  logic                               step;
  logic                               out_valid_r;
  logic                               out_last_r;
  logic                               out_last_nxt;
  logic signed [SB-1:0]               out_value_r;
  flc_pkg::cell_ctrl_t                ctrl;
  logic signed [SB-1:0]               cell_sum [MAX_TAPS];

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TCW'(1);
      coeff_r[0]  <= flc_pkg::CFG_DATA_BITS'(1);
      coeff_r[1]  <= '0;
      coeff_r[2]  <= '0;
      coeff_r[3]  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        flc_pkg::CFG_TAP_COUNT: tap_count_r <= cfg_data[TCW-1:0];
        flc_pkg::CFG_COEFF_0:   coeff_r[0]  <= cfg_data;
        flc_pkg::CFG_COEFF_1:   coeff_r[1]  <= cfg_data;
        flc_pkg::CFG_COEFF_2:   coeff_r[2]  <= cfg_data;
        flc_pkg::CFG_COEFF_3:   coeff_r[3]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    n_use = tap_count_r;
    if (tap_count_r == '0) begin
      n_use = TCW'(1);
    end else if (tap_count_r > TCW'(LIM)) begin
      n_use = TCW'(LIM);
    end
  end

  // control
  assign draining = (drain_r != '0);
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = draining || !out_free;
  assign in_fire  = in_valid && !in_stall;
  assign step     = in_fire || (draining && out_free);

  always_comb begin
    drain_nxt    = drain_r;
    out_last_nxt = 1'b0;
    ctrl.shift   = step;
    ctrl.clr     = 1'b0;
    if (in_fire) begin
      if (in_last_sample) begin
        if (n_use == TCW'(1)) begin
          out_last_nxt = 1'b1;
          ctrl.clr     = 1'b1;
        end else begin
          drain_nxt = DCW'(n_use - TCW'(1));
        end
      end
    end else if (draining && out_free) begin
      drain_nxt = drain_r - DCW'(1);
      if (drain_r == DCW'(1)) begin
        out_last_nxt = 1'b1;
        ctrl.clr     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r <= drain_nxt;
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_value_r <= cell_sum[0];
      out_last_r  <= out_last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_filtered_value = out_value_r;
  assign out_last_result    = out_last_r;

  // cell chain
  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_cell
    logic signed [COEFF_BITS-1:0] coeff;
    logic                         mac_en;
    logic signed [SB-1:0]         nb_sum;

    if (j < flc_pkg::REG_TAPS) begin : g_tap
      logic [flc_pkg::SLOT_BITS-1:0] slot;
      assign slot   = coeff_r[j / flc_pkg::TAPS_PER_REG]
                             [(j % flc_pkg::TAPS_PER_REG) * flc_pkg::SLOT_BITS +:
                              flc_pkg::SLOT_BITS];
      assign coeff  = COEFF_BITS'($signed(slot[CUSE-1:0]));
      assign mac_en = !draining && (TCW'(j) < n_use);
    end else begin : g_none
      assign coeff  = '0;
      assign mac_en = 1'b0;
    end

    if (j < MAX_TAPS - 1) begin : g_nb
      assign nb_sum = cell_sum[j + 1];
    end else begin : g_end
      assign nb_sum = '0;
    end

    flc_cell #(
      .SAMPLE_BITS(SAMPLE_BITS),
      .COEFF_BITS (COEFF_BITS)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .ctrl   (ctrl),
      .mac_en (mac_en),
      .sample (in_sample),
      .coeff  (coeff),
      .sum_in (nb_sum),
      .sum_out(cell_sum[j])
    );
  end

  // checks
  a_no_accept_in_drain: assert property (@(posedge clk) disable iff (!rst_n)
    draining |-> !in_fire)
    else $error("sample accepted during tail drain");

  a_drain_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_last_sample && (n_use != TCW'(1)) |=> drain_r == $past(DCW'(n_use - TCW'(1))))
    else $error("tail drain count wrong");

  a_last_on_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    draining && out_free && (drain_r == DCW'(1)) |=> out_valid_r && out_last_r && !draining)
    else $error("final tail beat not marked");

  a_last_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    step && out_last_nxt |-> ctrl.clr)
    else $error("final beat without clearing partial sums");

endmodule

`default_nettype wire
